// ===== rtl/cls_pkg.sv =====
// Shared types and constants for the covariance linear segmenter.
// Used by the controller, datapath, divider and top level; no dependencies.
package cls_pkg;

  localparam int DEF_MAX_SEGMENT = 256;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int FRAC_BITS       = 24;
  localparam int CFG_W           = 16;
  localparam int OUT_POINTS_W    = 9;
  localparam int OUT_FIX_W       = 48;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_UPD,
    CS_SX,
    CS_PROD,
    CS_NUMDEN,
    CS_DIV1,
    CS_WAIT1,
    CS_MULSX,
    CS_DIV2,
    CS_WAIT2,
    CS_VSTART,
    CS_VWAIT,
    CS_EMIT,
    CS_FLUSH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_UPD,
    DP_SX,
    DP_PROD,
    DP_NUMDEN,
    DP_DIV_SLOPE,
    DP_MULSX,
    DP_DIV_ICPT,
    DP_VSTART,
    DP_COMMIT,
    DP_EMIT_FULL,
    DP_EMIT_FAIL,
    DP_EMIT_FLUSH,
    DP_CLEAR
  } dp_op_t;

  typedef enum logic [1:0] {
    EK_FULL,
    EK_FAIL,
    EK_FLUSH
  } emit_kind_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

  typedef struct packed {
    logic full;
    logic ge2;
    logic div_done;
    logic ver_done;
    logic ver_fail;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/covariance_linear_segmenter.sv =====
// Top level of the covariance linear segmenter.
// Depends on cls_pkg, cls_ctrl and cls_datapath (which holds cls_divider).
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid, in_ready, in_opcode, in_sample      | in
//   result  | out_valid, out_ready, out_segment_points,     | out
//           | out_slope, out_intercept                      |
//   config  | cfg_wr_en, cfg_wr_data (error bound)          | in
//
// The time a sample takes grows with n, the points in the segment, and with the
// divider width DVW = SAMPLE_BITS + 3*clog2(MAX_SEGMENT+1) + 28 (71 by default);
// the two passes through the bit-serial divider and the one-read-a-cycle check of
// the sample store set it. A flush or a first sample skips the fit and the divider.
// Reset is synchronous and clears the segment state and the error bound.
// A result beat waits in the output register; a new input beat is taken meanwhile,
// and the block stalls only when a further beat is due before the previous one goes.
module covariance_linear_segmenter #(
  parameter int MAX_SEGMENT = cls_pkg::DEF_MAX_SEGMENT,
  parameter int SAMPLE_BITS = cls_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cls_pkg::OUT_POINTS_W-1:0]      out_segment_points,
  output logic signed [cls_pkg::OUT_FIX_W-1:0]  out_slope,
  output logic signed [cls_pkg::OUT_FIX_W-1:0]  out_intercept,
  input  logic                                  cfg_wr_en,
  input  logic [cls_pkg::CFG_W-1:0]             cfg_wr_data
);

  cls_pkg::dp_op_t     op;
  cls_pkg::dp_status_t status;

  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .status    (status),
    .op        (op)
  );

  cls_datapath #(
    .MAX_SEGMENT (MAX_SEGMENT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .in_sample          (in_sample),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_segment_points (out_segment_points),
    .out_slope          (out_slope),
    .out_intercept      (out_intercept)
  );

endmodule

// ===== rtl/cls_divider.sv =====
// Iterative signed-by-positive floor divider, one quotient bit per cycle.
// Depends on cls_pkg for the state type.
module cls_divider #(
  parameter int DVW = 71,
  parameter int DSW = 38
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [DVW-1:0] dividend,
  input  logic        [DSW-1:0] divisor,
  output logic                  done,
  output logic signed [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  cls_pkg::div_state_t state_r, state_nxt;
  logic [DVW-1:0] dvd_r;
  logic [DSW-1:0] dsr_r;
  logic [DSW:0]   rem_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r;
  logic           done_r;
  logic signed [DVW-1:0] quo_r;
  logic [DSW:0]   shifted;
  logic           qbit;

  assign shifted = {rem_r[DSW-1:0], dvd_r[DVW-1]};
  assign qbit    = (shifted >= {1'b0, dsr_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cls_pkg::DIV_IDLE: if (start) state_nxt = cls_pkg::DIV_ABS;
      cls_pkg::DIV_ABS:  state_nxt = cls_pkg::DIV_RUN;
      cls_pkg::DIV_RUN:  if (cnt_r == CW'(1)) state_nxt = cls_pkg::DIV_FIX;
      cls_pkg::DIV_FIX:  state_nxt = cls_pkg::DIV_IDLE;
      default:           state_nxt = cls_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cls_pkg::DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == cls_pkg::DIV_FIX);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cls_pkg::DIV_IDLE: begin
        if (start) begin
          dvd_r <= dividend;
          dsr_r <= divisor;
        end
      end
      cls_pkg::DIV_ABS: begin
        neg_r <= dvd_r[DVW-1];
        dvd_r <= dvd_r[DVW-1] ? (~dvd_r + DVW'(1)) : dvd_r;
        rem_r <= '0;
        cnt_r <= CW'(DVW);
      end
      cls_pkg::DIV_RUN: begin
        rem_r <= qbit ? (shifted - {1'b0, dsr_r}) : shifted;
        dvd_r <= {dvd_r[DVW-2:0], qbit};
        cnt_r <= cnt_r - CW'(1);
      end
      cls_pkg::DIV_FIX: begin
        // Floor for a negative dividend rounds the magnitude up when inexact.
        quo_r <= neg_r ? -$signed(dvd_r + DVW'(rem_r != '0)) : $signed(dvd_r);
      end
      default: begin
      end
    endcase
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == cls_pkg::DIV_FIX)
    else $error("divider done without a final correction step");

endmodule

// ===== rtl/cls_datapath.sv =====
// Datapath: sample store, running sums, line fit, bound check and output register.
// Depends on cls_pkg and cls_divider.
module cls_datapath #(
  parameter int MAX_SEGMENT = cls_pkg::DEF_MAX_SEGMENT,
  parameter int SAMPLE_BITS = cls_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cls_pkg::dp_op_t                       op,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  cfg_wr_en,
  input  logic [cls_pkg::CFG_W-1:0]             cfg_wr_data,
  output cls_pkg::dp_status_t                   status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cls_pkg::OUT_POINTS_W-1:0]      out_segment_points,
  output logic signed [cls_pkg::OUT_FIX_W-1:0]  out_slope,
  output logic signed [cls_pkg::OUT_FIX_W-1:0]  out_intercept
);

  localparam int F    = cls_pkg::FRAC_BITS;
  localparam int SB   = SAMPLE_BITS;
  localparam int NW   = $clog2(MAX_SEGMENT + 1);
  localparam int XW   = $clog2(MAX_SEGMENT);
  localparam int SYW  = SB + NW;
  localparam int SXYW = SB + 2 * NW;
  localparam int SXXW = 3 * NW + 1;
  localparam int SXW  = 2 * NW;
  localparam int P1W  = NW + 1 + SXYW;
  localparam int P2W  = SXW + 1 + SYW;
  localparam int P3W  = NW + 1 + SXXW;
  localparam int P4W  = 2 * SXW;
  localparam int NUMW = SB + 3 * NW + 2;
  localparam int DENW = 4 * NW + 2;
  localparam int SLW  = SB + F + 2;
  localparam int ICW  = SB + NW + F + 2;
  localparam int P5W  = SLW + SXW + 1;
  localparam int DVW  = SB + 3 * NW + F + 4;
  localparam int DSW  = DENW + 1;
  localparam int VW   = (ICW + 2 > cls_pkg::CFG_W + F + 2) ? ICW + 2 : cls_pkg::CFG_W + F + 2;

  logic signed [SB-1:0]   mem [MAX_SEGMENT];
  logic signed [SB-1:0]   y_r, rdata_r;
  logic [NW-1:0]          count_r;
  logic signed [SXYW-1:0] sxy_r;
  logic signed [SXXW-1:0] sxx_r;
  logic signed [SYW-1:0]  sy_r;
  logic signed [SLW-1:0]  line_slp_r, slp_r;
  logic signed [ICW-1:0]  line_icp_r, icp_r;
  logic [SXW-1:0]         sx_r;
  logic signed [P1W-1:0]  p1_r;
  logic signed [P2W-1:0]  p2_r;
  logic signed [P3W-1:0]  p3_r;
  logic [P4W-1:0]         p4_r;
  logic signed [P5W-1:0]  p5_r;
  logic signed [NUMW-1:0] num_r;
  logic signed [DENW-1:0] den_r;
  logic                   cap_icp_r;
  logic [cls_pkg::CFG_W-1:0] bound_r;
  logic [XW-1:0]          vidx_r;
  logic                   issue_r, chk_r, vact_r, fail_r;
  logic signed [VW-1:0]   acc_r;
  logic                   out_valid_r;
  logic [cls_pkg::OUT_POINTS_W-1:0]     out_points_r;
  logic signed [cls_pkg::OUT_FIX_W-1:0] out_slope_r, out_icp_r;

  logic signed [NW+SB:0]  xy_w;
  logic [2*NW-1:0]        xx_w, nn_w;
  logic signed [DVW-1:0]  div_dvd;
  logic [DSW-1:0]         div_dsr;
  logic                   div_start, div_done;
  logic signed [DVW-1:0]  div_quo;
  logic signed [VW-1:0]   d_w, tol_w;
  logic                   ver_done, out_free, emit, restart;
  logic [NW-1:0]          emit_cnt;

  assign xy_w = $signed({1'b0, count_r}) * y_r;
  assign xx_w = count_r * count_r;
  assign nn_w = count_r * (count_r - NW'(1));

  assign div_start = (op == cls_pkg::DP_DIV_SLOPE) || (op == cls_pkg::DP_DIV_ICPT);
  // Slope: floor((2*num*2^F + den) / (2*den)); intercept: floor((2*A + n) / (2*n)).
  assign div_dvd = (op == cls_pkg::DP_DIV_ICPT)
                 ? ((DVW'(sy_r) <<< (F + 1)) - (DVW'(p5_r) <<< 1)
                    + DVW'($signed({1'b0, count_r})))
                 : ((DVW'(num_r) <<< (F + 1)) + DVW'(den_r));
  assign div_dsr = (op == cls_pkg::DP_DIV_ICPT) ? DSW'({count_r, 1'b0})
                                                : DSW'({den_r, 1'b0});

  cls_divider #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign d_w   = acc_r - (VW'(rdata_r) <<< F);
  assign tol_w = $signed(VW'(bound_r) << F);

  assign ver_done = vact_r && !issue_r && !chk_r;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (op == cls_pkg::DP_EMIT_FULL) || (op == cls_pkg::DP_EMIT_FAIL) ||
                    (op == cls_pkg::DP_EMIT_FLUSH);
  assign restart  = (op == cls_pkg::DP_EMIT_FULL) || (op == cls_pkg::DP_EMIT_FAIL);
  assign emit_cnt = (op == cls_pkg::DP_EMIT_FAIL) ? count_r - NW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sxy_r       <= '0;
      sxx_r       <= '0;
      sy_r        <= '0;
      line_slp_r  <= '0;
      line_icp_r  <= '0;
      bound_r     <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      vact_r      <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) bound_r <= cfg_wr_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;

      if (op == cls_pkg::DP_UPD) begin
        count_r <= count_r + NW'(1);
        sxy_r   <= sxy_r + SXYW'(xy_w);
        sxx_r   <= sxx_r + SXXW'($signed({1'b0, xx_w}));
        sy_r    <= sy_r + SYW'(y_r);
      end
      if (restart) begin
        count_r <= NW'(1);
        sxy_r   <= '0;
        sxx_r   <= '0;
        sy_r    <= SYW'(y_r);
      end
      if ((op == cls_pkg::DP_EMIT_FLUSH) || (op == cls_pkg::DP_CLEAR)) begin
        count_r    <= '0;
        sxy_r      <= '0;
        sxx_r      <= '0;
        sy_r       <= '0;
        line_slp_r <= '0;
        line_icp_r <= '0;
      end
      if (op == cls_pkg::DP_COMMIT) begin
        line_slp_r <= slp_r;
        line_icp_r <= icp_r;
      end

      // The store is read one entry a cycle; each compare comes in the cycle after its read.
      if (op == cls_pkg::DP_VSTART) begin
        issue_r <= 1'b1;
        chk_r   <= 1'b0;
        vact_r  <= 1'b1;
        fail_r  <= 1'b0;
      end else begin
        chk_r <= issue_r;
        if (issue_r && (vidx_r == XW'(count_r - NW'(1)))) issue_r <= 1'b0;
        if (chk_r && ((d_w > tol_w) || (d_w < -tol_w))) fail_r <= 1'b1;
        if (ver_done) vact_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == cls_pkg::DP_LATCH) y_r <= in_sample;
    if (op == cls_pkg::DP_UPD) mem[count_r[XW-1:0]] <= y_r;
    else if (restart) mem[0] <= y_r;
    if (op == cls_pkg::DP_SX) sx_r <= nn_w >> 1;
    if (op == cls_pkg::DP_PROD) begin
      p1_r <= $signed({1'b0, count_r}) * sxy_r;
      p2_r <= $signed({1'b0, sx_r}) * sy_r;
      p3_r <= $signed({1'b0, count_r}) * sxx_r;
      p4_r <= sx_r * sx_r;
    end
    if (op == cls_pkg::DP_NUMDEN) begin
      num_r <= NUMW'(p1_r) - NUMW'(p2_r);
      den_r <= DENW'(p3_r) - DENW'($signed({1'b0, p4_r}));
    end
    if (op == cls_pkg::DP_MULSX) p5_r <= slp_r * $signed({1'b0, sx_r});
    if (div_start) cap_icp_r <= (op == cls_pkg::DP_DIV_ICPT);
    if (div_done) begin
      if (cap_icp_r) icp_r <= ICW'(div_quo);
      else slp_r <= SLW'(div_quo);
    end
    if (op == cls_pkg::DP_VSTART) begin
      vidx_r <= '0;
      acc_r  <= VW'(icp_r);
    end else begin
      if (issue_r) begin
        rdata_r <= mem[vidx_r];
        vidx_r  <= vidx_r + XW'(1);
      end
      if (chk_r) acc_r <= acc_r + VW'(slp_r);
    end
    if (emit) begin
      out_points_r <= cls_pkg::OUT_POINTS_W'(emit_cnt);
      out_slope_r  <= cls_pkg::OUT_FIX_W'(line_slp_r);
      out_icp_r    <= cls_pkg::OUT_FIX_W'(line_icp_r);
    end
  end

  assign status.full     = (count_r == NW'(MAX_SEGMENT));
  assign status.ge2      = (count_r >= NW'(2));
  assign status.div_done = div_done;
  assign status.ver_done = ver_done;
  assign status.ver_fail = fail_r;
  assign status.out_free = out_free;

  assign out_valid          = out_valid_r;
  assign out_segment_points = out_points_r;
  assign out_slope          = out_slope_r;
  assign out_intercept      = out_icp_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_SEGMENT))
    else $error("segment count beyond the store depth");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (emit_cnt >= NW'(2)) && out_free)
    else $error("segment emitted with too few points or over a pending beat");

  a_commit_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cls_pkg::DP_COMMIT) |-> ver_done && !fail_r)
    else $error("line committed without a passing bound check");

endmodule

// ===== rtl/cls_ctrl.sv =====
// Controller state machine: sequences sums, fit, divisions, check and emission.
// Depends on cls_pkg; drives cls_datapath through an operation code.
module cls_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_ready,
  input  cls_pkg::dp_status_t status,
  output cls_pkg::dp_op_t     op
);

  cls_pkg::ctrl_state_t state_r, state_nxt;
  cls_pkg::emit_kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cls_pkg::CS_IDLE;
      kind_r  <= cls_pkg::EK_FULL;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    op        = cls_pkg::DP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      cls_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = cls_pkg::DP_LATCH;
          if (in_opcode) begin
            state_nxt = cls_pkg::CS_FLUSH;
          end else if (status.full) begin
            kind_nxt  = cls_pkg::EK_FULL;
            state_nxt = cls_pkg::CS_EMIT;
          end else begin
            state_nxt = cls_pkg::CS_UPD;
          end
        end
      end
      cls_pkg::CS_UPD: begin
        op        = cls_pkg::DP_UPD;
        state_nxt = cls_pkg::CS_SX;
      end
      cls_pkg::CS_SX: begin
        if (status.ge2) begin
          op        = cls_pkg::DP_SX;
          state_nxt = cls_pkg::CS_PROD;
        end else begin
          state_nxt = cls_pkg::CS_IDLE;
        end
      end
      cls_pkg::CS_PROD: begin
        op        = cls_pkg::DP_PROD;
        state_nxt = cls_pkg::CS_NUMDEN;
      end
      cls_pkg::CS_NUMDEN: begin
        op        = cls_pkg::DP_NUMDEN;
        state_nxt = cls_pkg::CS_DIV1;
      end
      cls_pkg::CS_DIV1: begin
        op        = cls_pkg::DP_DIV_SLOPE;
        state_nxt = cls_pkg::CS_WAIT1;
      end
      cls_pkg::CS_WAIT1: begin
        if (status.div_done) state_nxt = cls_pkg::CS_MULSX;
      end
      cls_pkg::CS_MULSX: begin
        op        = cls_pkg::DP_MULSX;
        state_nxt = cls_pkg::CS_DIV2;
      end
      cls_pkg::CS_DIV2: begin
        op        = cls_pkg::DP_DIV_ICPT;
        state_nxt = cls_pkg::CS_WAIT2;
      end
      cls_pkg::CS_WAIT2: begin
        if (status.div_done) state_nxt = cls_pkg::CS_VSTART;
      end
      cls_pkg::CS_VSTART: begin
        op        = cls_pkg::DP_VSTART;
        state_nxt = cls_pkg::CS_VWAIT;
      end
      cls_pkg::CS_VWAIT: begin
        if (status.ver_done) begin
          if (status.ver_fail) begin
            kind_nxt  = cls_pkg::EK_FAIL;
            state_nxt = cls_pkg::CS_EMIT;
          end else begin
            op        = cls_pkg::DP_COMMIT;
            state_nxt = cls_pkg::CS_IDLE;
          end
        end
      end
      cls_pkg::CS_FLUSH: begin
        if (status.ge2) begin
          kind_nxt  = cls_pkg::EK_FLUSH;
          state_nxt = cls_pkg::CS_EMIT;
        end else begin
          op        = cls_pkg::DP_CLEAR;
          state_nxt = cls_pkg::CS_IDLE;
        end
      end
      cls_pkg::CS_EMIT: begin
        // Holds until the output register can take the new beat.
        if (status.out_free) begin
          state_nxt = cls_pkg::CS_IDLE;
          case (kind_r)
            cls_pkg::EK_FULL:  op = cls_pkg::DP_EMIT_FULL;
            cls_pkg::EK_FAIL:  op = cls_pkg::DP_EMIT_FAIL;
            cls_pkg::EK_FLUSH: op = cls_pkg::DP_EMIT_FLUSH;
            default:           op = cls_pkg::DP_EMIT_FLUSH;
          endcase
        end
      end
      default: begin
        state_nxt = cls_pkg::CS_IDLE;
      end
    endcase
  end

endmodule
